@@ hdl/dirty_byte_run_tracker_assert.svh @@
// ============================================================================
// Assertion macros for the dirty byte run tracker
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ============================================================================
`ifndef DIRTY_BYTE_RUN_TRACKER_ASSERT_SVH
`define DIRTY_BYTE_RUN_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge out of reset.
`define DRBT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// When the antecedent holds, the consequent must hold in the same cycle.
`define DRBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DRBT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define DRBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/drbt_pkg.sv @@
// ============================================================================
// drbt_pkg
// Shared widths, codes, controller interface types and helper functions.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package drbt_pkg;

    // Dirty map storage: one memory word holds this many dirty bits.
    localparam int WORD_W   = 32;
    localparam int OFF_W    = 5;
    localparam int CNT_W    = OFF_W + 1;

    localparam int KIND_W   = 2;
    localparam int COL_W    = 8;
    localparam int PAGE_W   = 8;
    localparam int PROW_W   = 8;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int CURSOR_W = 11;
    localparam int CFG_W    = 8;
    localparam int PC_W     = 4;
    localparam int CIDX_W   = 1;

    localparam int PIXEL_PAGE_SHIFT = 3;

    localparam logic [KIND_W-1:0] KIND_MARK_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH      = 2'd2;

    localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
    localparam logic [CIDX_W-1:0] REG_PAGE_COUNT   = 1'b1;

    localparam logic [COL_W-1:0] SCREEN_WIDTH_RST = 8'd128;
    localparam logic [PC_W-1:0]  PAGE_COUNT_RST   = 4'd8;

    typedef struct packed {
        logic load_item;
        logic dispatch;
        logic mark_write;
        logic scan_step;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cursor_out;
        logic              scan_done;
        logic              out_free;
    } ctrl_status_t;

    // Index of the lowest set bit; WORD_W when no bit is set.
    function automatic logic [CNT_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] idx;
        idx = CNT_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = CNT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hdl/drbt_ram.sv @@
// ============================================================================
// drbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module drbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/drbt_ctrl.sv @@
// ============================================================================
// drbt_ctrl
// Sequencer: takes one word, steps it through mark or scan, posts the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module drbt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire drbt_pkg::ctrl_status_t status,
    output drbt_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DISPATCH = 5'b00010,
        ST_MARK_WR  = 5'b00100,
        ST_SCAN     = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                unique case (status.kind) inside
                    drbt_pkg::KIND_MARK_BYTE, drbt_pkg::KIND_MARK_PIXEL:
                        state_next = ST_MARK_WR;
                    drbt_pkg::KIND_FETCH:
                        state_next = status.cursor_out ? ST_DONE : ST_SCAN;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_MARK_WR:
            begin
                cmd.mark_write = 1'b1;
                state_next     = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/drbt_datapath.sv @@
// ============================================================================
// drbt_datapath
// Dirty map memory, configuration, scan cursor, word scanner and result slot.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "dirty_byte_run_tracker_assert.svh"

module drbt_datapath #(
    parameter int ROW_STRIDE = 128,
    parameter int MAX_PAGES  = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [drbt_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [drbt_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic [drbt_pkg::KIND_W-1:0]   in_kind,
    input  wire logic [drbt_pkg::COL_W-1:0]    in_column,
    input  wire logic [drbt_pkg::PAGE_W-1:0]   in_page,
    input  wire logic [drbt_pkg::PROW_W-1:0]   in_pixel_row,
    input  wire drbt_pkg::ctrl_cmd_t           cmd,
    output drbt_pkg::ctrl_status_t             status,
    input  wire logic                          m_tready,
    output logic                               out_valid,
    output logic                               out_found,
    output logic [drbt_pkg::START_W-1:0]       out_start,
    output logic [drbt_pkg::LEN_W-1:0]         out_length
);

    localparam int WORD_W   = drbt_pkg::WORD_W;
    localparam int OFF_W    = drbt_pkg::OFF_W;
    localparam int CNT_W    = drbt_pkg::CNT_W;
    localparam int MAP_BITS = MAX_PAGES * ROW_STRIDE;
    localparam int ROWS     = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W    = $clog2(MAP_BITS + 1);
    // One spare bit so that a row base plus a word never wraps.
    localparam int POS_W    = ((IDX_W > drbt_pkg::CURSOR_W) ? IDX_W : drbt_pkg::CURSOR_W) + 1;
    localparam int PE_W     = $clog2(MAX_PAGES + 1);

    // Configuration and cursor.
    logic [drbt_pkg::COL_W-1:0]    sw_reg, sw_next;
    logic [drbt_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [drbt_pkg::CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [ROWS-1:0]               row_valid_reg, row_valid_next;

    // Item held while it is worked on.
    logic [drbt_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [drbt_pkg::COL_W-1:0]    col_reg, col_next;
    logic [drbt_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [drbt_pkg::PROW_W-1:0]   prow_reg, prow_next;

    // Scan state.
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [POS_W-1:0]              start_reg, start_next;
    logic                          in_run_reg, in_run_next;

    // Finished result and output slot.
    logic                          res_found_reg, res_found_next;
    logic [drbt_pkg::START_W-1:0]  res_start_reg, res_start_next;
    logic [drbt_pkg::LEN_W-1:0]    res_len_reg, res_len_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg, out_found_next;
    logic [drbt_pkg::START_W-1:0]  out_start_reg, out_start_next;
    logic [drbt_pkg::LEN_W-1:0]    out_len_reg, out_len_next;

    logic [PE_W-1:0]               pages_eff;
    logic [POS_W-1:0]              size_w;
    logic [POS_W-1:0]              cur_pos;
    logic                          cursor_out;

    logic [drbt_pkg::PAGE_W-1:0]   mark_page;
    logic                          mark_ok;
    logic [POS_W-1:0]              mark_idx;
    logic [ROW_AW-1:0]             mark_row;
    logic [OFF_W-1:0]              mark_off;
    logic [WORD_W-1:0]             mark_word;

    logic [WORD_W-1:0]             rdata;
    logic [ROW_AW-1:0]             raddr;
    logic                          ram_we;
    logic [ROW_AW-1:0]             waddr;
    logic [WORD_W-1:0]             wdata;

    logic [POS_W-1:0]              row_base;
    logic [ROW_AW-1:0]             scan_row;
    logic [OFF_W-1:0]              lo_off;
    logic [WORD_W-1:0]             scan_word;
    logic [POS_W-1:0]              rem;
    logic [WORD_W-1:0]             range_m;
    logic [WORD_W-1:0]             ge_lo;
    logic [WORD_W-1:0]             ge_s;
    logic [WORD_W-1:0]             clr_m;
    logic [WORD_W-1:0]             zero_m;
    logic [CNT_W-1:0]              first_set;
    logic [CNT_W-1:0]              first_clr;
    logic [CNT_W-1:0]              s_off;
    logic                          hit;
    logic                          end_hit;
    logic                          active;
    logic [POS_W-1:0]              next_base;
    logic                          next_beyond;
    logic                          scan_done;
    logic [POS_W-1:0]              run_start;
    logic [POS_W-1:0]              run_end;
    logic [POS_W-1:0]              run_len;

    // Page count above the page capacity acts as the capacity.
    assign pages_eff  = (int'(pc_reg) > MAX_PAGES) ? PE_W'(MAX_PAGES) : PE_W'(pc_reg);
    assign size_w     = POS_W'(pages_eff) * POS_W'(ROW_STRIDE);
    assign cur_pos    = POS_W'(cursor_reg);
    assign cursor_out = (cur_pos >= size_w);

    // Mark addressing.
    assign mark_page = (kind_reg == drbt_pkg::KIND_MARK_PIXEL)
                     ? (prow_reg >> drbt_pkg::PIXEL_PAGE_SHIFT) : page_reg;
    assign mark_ok   = ((kind_reg == drbt_pkg::KIND_MARK_BYTE)
                        || (kind_reg == drbt_pkg::KIND_MARK_PIXEL))
                     && (col_reg < sw_reg)
                     && (int'(col_reg) < ROW_STRIDE)
                     && (int'(mark_page) < int'(pages_eff));
    assign mark_idx  = POS_W'(mark_page) * POS_W'(ROW_STRIDE) + POS_W'(col_reg);
    assign mark_row  = mark_idx[OFF_W +: ROW_AW];
    assign mark_off  = mark_idx[OFF_W-1:0];
    // A row never written still reads as all dirty.
    assign mark_word = (row_valid_reg[mark_row] ? rdata : '1) | (WORD_W'(1) << mark_off);

    // Word scanner over the row at pos_reg.
    assign row_base  = {pos_reg[POS_W-1:OFF_W], OFF_W'(0)};
    assign scan_row  = pos_reg[OFF_W +: ROW_AW];
    assign lo_off    = pos_reg[OFF_W-1:0];
    assign scan_word = row_valid_reg[scan_row] ? rdata : '1;
    assign rem       = size_w - row_base;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            range_m[i] = (rem > POS_W'(i));
            ge_lo[i]   = (OFF_W'(i) >= lo_off);
        end
    end

    assign first_set = drbt_pkg::first_one(scan_word & range_m & ge_lo);
    assign hit       = !first_set[OFF_W];
    assign s_off     = in_run_reg ? {1'b0, lo_off} : first_set;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            ge_s[i] = (CNT_W'(i) >= s_off);
        end
    end

    assign zero_m    = ~(scan_word & range_m) & ge_s;
    assign first_clr = drbt_pkg::first_one(zero_m);
    assign end_hit   = !first_clr[OFF_W];

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            clr_m[i] = ge_s[i] && (CNT_W'(i) < first_clr);
        end
    end

    assign active      = in_run_reg || hit;
    assign next_base   = row_base + POS_W'(WORD_W);
    assign next_beyond = (next_base >= size_w);
    assign scan_done   = (active && end_hit) || next_beyond;
    assign run_start   = in_run_reg ? start_reg : (row_base + POS_W'(first_set));
    assign run_end     = end_hit ? (row_base + POS_W'(first_clr)) : next_base;
    assign run_len     = run_end - run_start;

    // Memory ports.
    always_comb
    begin
        if (cmd.scan_step)
        begin
            raddr = next_base[OFF_W +: ROW_AW];
        end
        else if (kind_reg == drbt_pkg::KIND_FETCH)
        begin
            raddr = cur_pos[OFF_W +: ROW_AW];
        end
        else
        begin
            raddr = mark_row;
        end
    end

    assign ram_we = (cmd.mark_write && mark_ok) || (cmd.scan_step && active);
    assign waddr  = cmd.scan_step ? scan_row : mark_row;
    assign wdata  = cmd.scan_step ? (scan_word & ~clr_m) : mark_word;

    drbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sw_next        = sw_reg;
        pc_next        = pc_reg;
        cursor_next    = cursor_reg;
        row_valid_next = row_valid_reg;
        kind_next      = kind_reg;
        col_next       = col_reg;
        page_next      = page_reg;
        prow_next      = prow_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        in_run_next    = in_run_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_len_next   = res_len_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                drbt_pkg::REG_SCREEN_WIDTH: sw_next = cfg_wdata;
                drbt_pkg::REG_PAGE_COUNT:   pc_next = cfg_wdata[drbt_pkg::PC_W-1:0];
                default:                    sw_next = sw_reg;
            endcase
        end

        if (cmd.load_item)
        begin
            kind_next = in_kind;
            col_next  = in_column;
            page_next = in_page;
            prow_next = in_pixel_row;
        end

        if (cmd.dispatch)
        begin
            pos_next       = cur_pos;
            in_run_next    = 1'b0;
            res_found_next = 1'b0;
            res_start_next = '0;
            res_len_next   = '0;
            if ((kind_reg == drbt_pkg::KIND_FETCH) && cursor_out)
            begin
                cursor_next = '0;
            end
        end

        if (ram_we)
        begin
            row_valid_next[waddr] = 1'b1;
        end

        if (cmd.scan_step)
        begin
            if (scan_done)
            begin
                in_run_next = 1'b0;
                if (active)
                begin
                    res_found_next = 1'b1;
                    res_start_next = run_start[drbt_pkg::START_W-1:0];
                    res_len_next   = run_len[drbt_pkg::LEN_W-1:0];
                    cursor_next    = run_end[drbt_pkg::CURSOR_W-1:0];
                end
                else
                begin
                    cursor_next = '0;
                end
            end
            else
            begin
                pos_next    = next_base;
                in_run_next = active;
                if (!in_run_reg)
                begin
                    start_next = run_start;
                end
            end
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_found_next = res_found_reg;
            out_start_next = res_start_reg;
            out_len_next   = res_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= drbt_pkg::SCREEN_WIDTH_RST;
            pc_reg        <= drbt_pkg::PAGE_COUNT_RST;
            cursor_reg    <= '0;
            row_valid_reg <= '0;
            in_run_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sw_reg        <= sw_next;
            pc_reg        <= pc_next;
            cursor_reg    <= cursor_next;
            row_valid_reg <= row_valid_next;
            in_run_reg    <= in_run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        col_reg       <= col_next;
        page_reg      <= page_next;
        prow_reg      <= prow_next;
        pos_reg       <= pos_next;
        start_reg     <= start_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_len_reg   <= res_len_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
    end

    assign status.kind       = kind_reg;
    assign status.cursor_out = cursor_out;
    assign status.scan_done  = scan_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_start  = out_start_reg;
    assign out_length = out_len_reg;

    `DRBT_ASSERT_ALWAYS(a_row_valid_sticky, clk, rst_n, (row_valid_reg & $past(row_valid_reg)) == $past(row_valid_reg), "row valid bit fell")
    `DRBT_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, cmd.scan_step, pos_reg < size_w, "scan position beyond tracked range")
    `DRBT_ASSERT_IMPLY(a_push_slot_free, clk, rst_n, cmd.push, !out_valid_reg || m_tready, "result pushed over a pending word")
    `DRBT_ASSERT_IMPLY(a_no_run_zero, clk, rst_n, out_valid_reg && !out_found_reg, (out_start_reg == '0) && (out_len_reg == '0), "empty result carries data")

endmodule

`default_nettype wire

@@ hdl/dirty_byte_run_tracker.sv @@
// ============================================================================
// dirty_byte_run_tracker
// Dirty bit per display byte with marking and run extraction.
// ============================================================================
// Usage:
// Words enter on the s_ stream: s_tuser carries the kind (mark byte, mark
// pixel, fetch run), s_tdata the column, page and pixel row. Every word gives
// exactly one result word on the m_ stream: m_tuser says whether a run was
// found, m_tdata carries the run start and length (zero for marks).
// The block works on one word at a time. A mark goes through dispatch, a map
// write and the result post; a fetch goes through dispatch, a scan over the
// 32-bit map rows that it touches (one row read and written back per cycle
// through the map memory; a full pass covers 1024 bytes) and the result post.
// A fetch whose cursor lies beyond the tracked range skips the scan. The next
// word is accepted the cycle after its result is posted to the output register.
// The output register holds a result while m_tready is low; the block then
// finishes the next word and waits to post it until the register is taken.
// Reset clears per-row valid bits so the whole map reads as dirty at once,
// with no clearing pass; the cursor returns to 0 and the registers to their
// defaults. Configuration writes are taken at any edge with cfg_we high.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dirty_byte_run_tracker #(
    parameter int ROW_STRIDE = 128,
    parameter int MAX_PAGES  = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [drbt_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [drbt_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,  // column, page, pixel_row
    input  wire logic [1:0]                  s_tuser,  // kind
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,  // run_start, run_length
    output logic [0:0]                       m_tuser   // run_found
);

    drbt_pkg::ctrl_cmd_t    cmd;
    drbt_pkg::ctrl_status_t status;

    logic                          out_found;
    logic [drbt_pkg::START_W-1:0]  out_start;
    logic [drbt_pkg::LEN_W-1:0]    out_length;

    drbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drbt_datapath #(
        .ROW_STRIDE (ROW_STRIDE),
        .MAX_PAGES  (MAX_PAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_kind      (s_tuser),
        .in_column    (s_tdata[7:0]),
        .in_page      (s_tdata[15:8]),
        .in_pixel_row (s_tdata[23:16]),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .out_found    (out_found),
        .out_start    (out_start),
        .out_length   (out_length)
    );

    assign m_tdata = {3'b000, out_length, out_start};
    assign m_tuser = out_found;

endmodule

`default_nettype wire
